// ===== rtl/grid_ray_caster_defines.svh =====
// ----------------------------------------------------------------------------
// grid_ray_caster_defines
// assertion macros for the grid ray caster, removed when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_CASTER_DEFINES_SVH
`define GRID_RAY_CASTER_DEFINES_SVH

`ifndef ASSERT_OFF
`define GRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GRC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GRC_ASSERT(label, prop, msg)
`define GRC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/grc_pkg.sv =====
// ----------------------------------------------------------------------------
// grc_pkg
// shared constants, payload words and control structs of the grid ray caster
// ----------------------------------------------------------------------------
package grc_pkg;

  localparam int MAP_DIM_DEF = 64;
  localparam int FRAC_BITS   = 16;
  localparam int ANGLE_BITS  = 12;
  localparam int CFG_W       = 7;
  localparam int TILE_W      = 6;
  localparam int POS_W       = 22;
  localparam int OUT_W       = 24;
  localparam int WALK_W      = 32;
  localparam int CORD_W      = 34;
  localparam int CORD_STEPS  = 30;
  localparam int MAG_W       = 31;
  localparam int SAT_SHIFT   = 10;
  localparam int RAT_W       = FRAC_BITS + SAT_SHIFT;
  localparam int SLOPE_W     = RAT_W + 2;
  localparam int SQ_W        = 64;
  localparam int ROOT_STEPS  = SQ_W / 2;
  localparam int SQ_TERMS    = 4;
  localparam int CNT_W       = 6;

  localparam logic OP_TILE = 1'b0;
  localparam logic OP_CAST = 1'b1;

  localparam logic REG_MAP_COLS = 1'b0;
  localparam logic REG_MAP_ROWS = 1'b1;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(64);

  // arctangent of 2^-i in units of 2^-32 turn
  localparam logic [29:0] ATAN_TURN [CORD_STEPS] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
    30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
    30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
    30'd20, 30'd10, 30'd5, 30'd3, 30'd1
  };

  typedef struct packed {
    logic                  op;
    logic [TILE_W-1:0]     tile_row;
    logic [TILE_W-1:0]     tile_col;
    logic                  tile_is_wall;
    logic [POS_W-1:0]      pos_x;
    logic [POS_W-1:0]      pos_y;
    logic [ANGLE_BITS-1:0] heading;
  } req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] hit_x;
    logic signed [OUT_W-1:0] hit_y;
    logic [OUT_W-1:0]        distance;
    logic                    vertical_hit;
  } rsp_t;

  typedef struct packed {
    logic             clear_step;
    logic             tile_write;
    logic             load_ray;
    logic             cord_step;
    logic             div_load;
    logic             div_step;
    logic             div_store;
    logic             walk_init;
    logic             walk_read;
    logic             walk_step;
    logic             walk_save;
    logic             sq_step;
    logic             sel_load;
    logic             root_step;
    logic             out_load;
    logic             pass;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic axis;
    logic in_map;
    logic wall;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/grc_chan_if.sv =====
// ----------------------------------------------------------------------------
// grc_chan_if
// valid/ready channel carrying one payload word
// ----------------------------------------------------------------------------
interface grc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/grc_ctrl.sv =====
// ----------------------------------------------------------------------------
// grc_ctrl
// sequencer of the ray caster: map clear, cordic, divides, walks, root
// ----------------------------------------------------------------------------
module grc_ctrl import grc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_op,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [12:0] {
    ST_CLEAR  = 13'b0000000000001,
    ST_IDLE   = 13'b0000000000010,
    ST_ROT    = 13'b0000000000100,
    ST_DIVSET = 13'b0000000001000,
    ST_DIV    = 13'b0000000010000,
    ST_DIVEND = 13'b0000000100000,
    ST_WINIT  = 13'b0000001000000,
    ST_WRD    = 13'b0000010000000,
    ST_WCHK   = 13'b0000100000000,
    ST_SQ     = 13'b0001000000000,
    ST_SEL    = 13'b0010000000000,
    ST_ROOT   = 13'b0100000000000,
    ST_DONE   = 13'b1000000000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             pass, pass_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
      pass  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pass  <= pass_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    pass_next  = pass;
    cmd        = '0;
    cmd.pass   = pass;
    cmd.cnt    = cnt;
    in_ready   = (state == ST_IDLE);
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_CAST) begin
            cmd.load_ray = 1'b1;
            cnt_next     = '0;
            pass_next    = 1'b0;
            state_next   = ST_ROT;
          end else begin
            cmd.tile_write = 1'b1;
          end
        end
      end
      ST_ROT: begin
        if (stat.axis) begin
          state_next = ST_DIVSET;
        end else begin
          cmd.cord_step = 1'b1;
          cnt_next      = cnt + 1'b1;
          if (cnt == CNT_W'(CORD_STEPS - 1)) state_next = ST_DIVSET;
        end
      end
      ST_DIVSET: begin
        cmd.div_load = 1'b1;
        cnt_next     = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(RAT_W - 1)) state_next = ST_DIVEND;
      end
      ST_DIVEND: begin
        cmd.div_store = 1'b1;
        if (!pass) begin
          pass_next  = 1'b1;
          state_next = ST_DIVSET;
        end else begin
          pass_next  = 1'b0;
          state_next = ST_WINIT;
        end
      end
      ST_WINIT: begin
        cmd.walk_init = 1'b1;
        state_next    = ST_WRD;
      end
      ST_WRD: begin
        if (!stat.in_map) begin
          cmd.walk_save = 1'b1;
          if (!pass) begin
            pass_next  = 1'b1;
            state_next = ST_WINIT;
          end else begin
            cnt_next   = '0;
            state_next = ST_SQ;
          end
        end else begin
          cmd.walk_read = 1'b1;
          state_next    = ST_WCHK;
        end
      end
      ST_WCHK: begin
        if (stat.wall) begin
          cmd.walk_save = 1'b1;
          if (!pass) begin
            pass_next  = 1'b1;
            state_next = ST_WINIT;
          end else begin
            cnt_next   = '0;
            state_next = ST_SQ;
          end
        end else begin
          cmd.walk_step = 1'b1;
          state_next    = ST_WRD;
        end
      end
      ST_SQ: begin
        cmd.sq_step = 1'b1;
        cnt_next    = cnt + 1'b1;
        if (cnt == CNT_W'(SQ_TERMS - 1)) state_next = ST_SEL;
      end
      ST_SEL: begin
        cmd.sel_load = 1'b1;
        cnt_next     = '0;
        state_next   = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == CNT_W'(ROOT_STEPS - 1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

// ===== rtl/grc_dpath.sv =====
// ----------------------------------------------------------------------------
// grc_dpath
// wall map memory, cordic, shared divider, grid walker, squares, root, output
// ----------------------------------------------------------------------------
module grc_dpath import grc_pkg::*; #(
  parameter int MAP_DIM = MAP_DIM_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  req_t             in_data,
  input  cmd_t             cmd,
  output stat_t            stat,
  output logic             out_valid,
  input  logic             out_ready,
  output rsp_t             out_data
);

  localparam int MEM_DEPTH = MAP_DIM * MAP_DIM;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int TC_W      = WALK_W - FRAC_BITS;
  localparam int SQM_W     = 2 * (WALK_W - 1);
  localparam int ATAN_IW   = $clog2(CORD_STEPS);
  localparam logic signed [WALK_W-1:0] ONE      = WALK_W'(2 ** FRAC_BITS);
  localparam logic [ANGLE_BITS-1:0]    QUARTER  = ANGLE_BITS'(2 ** (ANGLE_BITS - 2));
  localparam logic [ANGLE_BITS-1:0]    HALF     = ANGLE_BITS'(2 ** (ANGLE_BITS - 1));
  localparam logic [ANGLE_BITS-1:0]    THREEQ   = ANGLE_BITS'(3 * 2 ** (ANGLE_BITS - 2));
  localparam logic [RAT_W-1:0]         RAT_MAX  = '1;
  localparam logic [SQ_W-1:0]          ROOT_TOP = SQ_W'(1) << (SQ_W - 2);
  localparam logic signed [WALK_W-1:0] OUT_HI   = WALK_W'(2 ** (OUT_W - 1) - 1);
  localparam logic signed [WALK_W-1:0] OUT_LO   = ~OUT_HI;
  localparam logic [OUT_W-1:0]         DIST_MAX = '1;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [WALK_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > OUT_HI)      r = OUT_HI[OUT_W-1:0];
    else if (v < OUT_LO) r = OUT_LO[OUT_W-1:0];
    else                 r = v[OUT_W-1:0];
    return r;
  endfunction

  // configuration
  logic [CFG_W-1:0] map_cols, map_rows, eff_cols, eff_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_cols <= DIM_RESET;
      map_rows <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAP_COLS: map_cols <= cfg_data;
        REG_MAP_ROWS: map_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_cols = (int'(map_cols) > MAP_DIM) ? CFG_W'(MAP_DIM) : map_cols;
  assign eff_rows = (int'(map_rows) > MAP_DIM) ? CFG_W'(MAP_DIM) : map_rows;

  logic signed [WALK_W-1:0] lim_x, lim_y;
  assign lim_x = {{(WALK_W-CFG_W-FRAC_BITS){1'b0}}, eff_cols, {FRAC_BITS{1'b0}}};
  assign lim_y = {{(WALK_W-CFG_W-FRAC_BITS){1'b0}}, eff_rows, {FRAC_BITS{1'b0}}};

  // ray set-up and cordic
  logic [POS_W-1:0]         px, py;
  logic                     down, right, axis;
  logic [1:0]               quad;
  logic signed [CORD_W-1:0] cx, cy, cz, xs, ys, atan_e, dir_c, dir_s;
  logic [31:0]              phase;
  logic [ANGLE_BITS-1:0]    ang;

  assign ang    = in_data.heading;
  assign phase  = {ang, {(32-ANGLE_BITS){1'b0}}};
  assign xs     = cx >>> cmd.cnt;
  assign ys     = cy >>> cmd.cnt;
  assign atan_e = CORD_W'(ATAN_TURN[cmd.cnt[ATAN_IW-1:0]]);

  always_ff @(posedge clk) begin
    if (cmd.load_ray) begin
      px    <= in_data.pos_x;
      py    <= in_data.pos_y;
      down  <= (ang != '0) && (ang < HALF);
      right <= (ang < QUARTER) || (ang > THREEQ);
      axis  <= (phase[29:0] == '0);
      quad  <= phase[31:30];
      cx    <= CORD_W'(1) << 30;
      cy    <= '0;
      cz    <= CORD_W'(phase[29:0]);
    end else if (cmd.cord_step) begin
      if (!cz[CORD_W-1]) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - atan_e;
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + atan_e;
      end
    end
  end

  always_comb begin
    case (quad)
      2'd0:    begin dir_c = cx;  dir_s = cy;  end
      2'd1:    begin dir_c = -cy; dir_s = cx;  end
      2'd2:    begin dir_c = -cx; dir_s = -cy; end
      default: begin dir_c = cy;  dir_s = -cx; end
    endcase
  end

  // shared restoring divider: tan then cot
  logic signed [CORD_W-1:0]  num, den, num_abs, den_abs;
  logic [MAG_W-1:0]          an, ad, dv_rem, dv_den;
  logic [RAT_W-1:0]          dv_low, dv_q, dv_mag;
  logic                      dv_sat, dv_neg, dv_ge;
  logic [MAG_W:0]            dv_r2, dv_diff;
  logic signed [SLOPE_W-1:0] dv_val, tanv, cotv;

  assign num     = cmd.pass ? dir_c : dir_s;
  assign den     = cmd.pass ? dir_s : dir_c;
  assign num_abs = num[CORD_W-1] ? -num : num;
  assign den_abs = den[CORD_W-1] ? -den : den;
  assign an      = num_abs[MAG_W-1:0];
  assign ad      = den_abs[MAG_W-1:0];
  assign dv_r2   = {dv_rem, dv_low[RAT_W-1]};
  assign dv_ge   = dv_r2 >= {1'b0, dv_den};
  assign dv_diff = dv_r2 - {1'b0, dv_den};
  assign dv_mag  = dv_sat ? RAT_MAX : dv_q;
  assign dv_val  = dv_neg ? -signed'({2'b00, dv_mag}) : signed'({2'b00, dv_mag});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dv_den <= ad;
      dv_rem <= an >> SAT_SHIFT;
      dv_low <= {an[SAT_SHIFT-1:0], {FRAC_BITS{1'b0}}};
      dv_q   <= '0;
      dv_sat <= (ad == '0) || ({{SAT_SHIFT{1'b0}}, an} >= {ad, {SAT_SHIFT{1'b0}}});
      dv_neg <= (ad == '0) ? num[CORD_W-1] : (num[CORD_W-1] != den[CORD_W-1]);
    end else if (cmd.div_step) begin
      dv_rem <= dv_ge ? dv_diff[MAG_W-1:0] : dv_r2[MAG_W-1:0];
      dv_q   <= {dv_q[RAT_W-2:0], dv_ge};
      dv_low <= {dv_low[RAT_W-2:0], 1'b0};
    end
    if (cmd.div_store) begin
      if (cmd.pass) cotv <= dv_val;
      else          tanv <= dv_val;
    end
  end

  // grid walker: along axis a steps one tile, axis b steps by the slope
  logic signed [WALK_W-1:0]   px_w, py_w, base_a, other, a0, dlt, slope_e, slope_abs;
  logic signed [2*WALK_W-1:0] prod;
  logic signed [WALK_W-1:0]   wa, wb, sa, sb, cur_x, cur_y, hx, hy, vx, vy;
  logic                       face_a, face_b;
  logic signed [SLOPE_W-1:0]  slope;
  logic signed [TC_W-1:0]     tcol, trow, eff_c_t, eff_r_t;
  logic                       t_out, tile_out_q, rd_bit;
  logic [ADDR_W-1:0]          raddr;

  assign px_w      = WALK_W'(px);
  assign py_w      = WALK_W'(py);
  assign base_a    = cmd.pass ? px_w : py_w;
  assign other     = cmd.pass ? py_w : px_w;
  assign face_a    = cmd.pass ? right : down;
  assign face_b    = cmd.pass ? down : right;
  assign slope     = cmd.pass ? tanv : cotv;
  assign slope_e   = WALK_W'(slope);
  assign slope_abs = slope_e[WALK_W-1] ? -slope_e : slope_e;
  assign a0        = {base_a[WALK_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}} + (face_a ? ONE : '0);
  assign dlt       = a0 - base_a;
  assign prod      = dlt * slope_e;

  assign cur_x = cmd.pass ? wa : wb;
  assign cur_y = cmd.pass ? wb : wa;

  assign eff_c_t = TC_W'(eff_cols);
  assign eff_r_t = TC_W'(eff_rows);
  assign tcol    = signed'(cur_x[WALK_W-1:FRAC_BITS]) - TC_W'(cmd.pass && !right);
  assign trow    = signed'(cur_y[WALK_W-1:FRAC_BITS]) - TC_W'(!cmd.pass && !down);
  assign t_out   = (tcol < 0) || (trow < 0) || (tcol >= eff_c_t) || (trow >= eff_r_t);
  assign raddr   = ADDR_W'(ADDR_W'(trow) * ADDR_W'(MAP_DIM) + ADDR_W'(tcol));

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      wa <= a0;
      wb <= other + signed'(prod[WALK_W+FRAC_BITS-1:FRAC_BITS]);
      sa <= face_a ? ONE : -ONE;
      sb <= face_b ? slope_abs : -slope_abs;
    end else if (cmd.walk_step) begin
      wa <= wa + sa;
      wb <= wb + sb;
    end
    if (cmd.walk_read) tile_out_q <= t_out;
    if (cmd.walk_save) begin
      if (cmd.pass) begin
        vx <= cur_x;
        vy <= cur_y;
      end else begin
        hx <= cur_x;
        hy <= cur_y;
      end
    end
  end

  // wall map, cleared by a sweep after reset
  logic              wall_mem [MEM_DEPTH];
  logic [ADDR_W-1:0] clr_addr, waddr;
  logic              mem_we, wdata, tile_ok;

  assign tile_ok = (int'(in_data.tile_row) < MAP_DIM) && (int'(in_data.tile_col) < MAP_DIM);
  assign mem_we  = cmd.clear_step || (cmd.tile_write && tile_ok);
  assign wdata   = cmd.clear_step ? 1'b0 : in_data.tile_is_wall;
  assign waddr   = cmd.clear_step ? clr_addr
                 : ADDR_W'(ADDR_W'(in_data.tile_row) * ADDR_W'(MAP_DIM)
                           + ADDR_W'(in_data.tile_col));

  always_ff @(posedge clk) begin
    if (mem_we) wall_mem[waddr] <= wdata;
    rd_bit <= wall_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clear_step) clr_addr <= clr_addr + 1'b1;
  end

  // squared distances, one multiplier shared by the four terms
  logic signed [WALK_W-1:0] sq_d, sq_abs;
  logic [WALK_W-2:0]        sq_m;
  logic [SQM_W-1:0]         sq_p;
  logic [SQ_W-1:0]          sq, hsq, vsq;

  always_comb begin
    case (cmd.cnt[1:0])
      2'd0:    sq_d = hx - px_w;
      2'd1:    sq_d = hy - py_w;
      2'd2:    sq_d = vx - px_w;
      default: sq_d = vy - py_w;
    endcase
  end

  assign sq_abs = sq_d[WALK_W-1] ? -sq_d : sq_d;
  assign sq_m   = sq_abs[WALK_W-2:0];
  assign sq_p   = sq_m * sq_m;
  assign sq     = SQ_W'(sq_p);

  always_ff @(posedge clk) begin
    if (cmd.sq_step) begin
      case (cmd.cnt[1:0])
        2'd0:    hsq <= sq;
        2'd1:    hsq <= hsq + sq;
        2'd2:    vsq <= sq;
        default: vsq <= vsq + sq;
      endcase
    end
  end

  // hit choice and bitwise integer root
  logic                     vert;
  logic [SQ_W-1:0]          rn, rres, rbit, rsum;
  logic signed [WALK_W-1:0] sel_x, sel_y;

  assign rsum = rres + rbit;

  always_ff @(posedge clk) begin
    if (cmd.sel_load) begin
      vert  <= !(vsq > hsq);
      rn    <= (vsq > hsq) ? hsq : vsq;
      sel_x <= (vsq > hsq) ? hx : vx;
      sel_y <= (vsq > hsq) ? hy : vy;
      rres  <= '0;
      rbit  <= ROOT_TOP;
    end else if (cmd.root_step) begin
      if (rn >= rsum) begin
        rn   <= rn - rsum;
        rres <= (rres >> 1) + rbit;
      end else begin
        rres <= rres >> 1;
      end
      rbit <= rbit >> 2;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.hit_x        <= sat_out(sel_x);
      out_data.hit_y        <= sat_out(sel_y);
      out_data.distance     <= (rres > SQ_W'(DIST_MAX)) ? DIST_MAX : rres[OUT_W-1:0];
      out_data.vertical_hit <= vert;
    end
  end

  assign stat.clear_last = (clr_addr == ADDR_W'(MEM_DEPTH - 1));
  assign stat.axis       = axis;
  assign stat.in_map     = !cur_x[WALK_W-1] && (cur_x < lim_x)
                        && !cur_y[WALK_W-1] && (cur_y < lim_y);
  assign stat.wall       = tile_out_q || rd_bit;
  assign stat.out_free   = !out_valid || out_ready;

endmodule

// ===== rtl/grid_ray_caster.sv =====
// ----------------------------------------------------------------------------
// grid_ray_caster
// fixed-point ray caster over a wall bitmap of the tile map
// ----------------------------------------------------------------------------
// req carries one word per item: op 0 writes one wall bit, op 1 casts a ray
// from (pos_x, pos_y) at the heading. rsp returns one word per cast with the
// nearer grid hit, its distance and the vertical flag; tile writes return
// nothing. cfg_we/cfg_index/cfg_data set the columns and rows in use.
// A cast loads the ray, runs the cordic (skipped on an axis angle), the
// divide for tan and then for cot, both walks testing one tile per step
// through the single read port of the map, the squares, the select, the
// root and the output load; the walk loop sets the length of a cast.
// One item is worked at a time; req.ready is high only while idle.
// After reset every tile of the map is swept to open, with req.ready low;
// columns and rows reset to 64.
// The result sits in an output register; a stalled rsp does not block the
// next item, but the following result waits until the register is taken.
// ----------------------------------------------------------------------------
`include "grid_ray_caster_defines.svh"

module grid_ray_caster import grc_pkg::*; #(
  parameter int MAP_DIM = MAP_DIM_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  grc_chan_if.sink         req,
  grc_chan_if.source       rsp
);

  cmd_t  cmd;
  stat_t stat;
  req_t  req_word;
  rsp_t  rsp_word;

  assign req_word = req.data;
  assign rsp.data = rsp_word;

  grc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_op    (req_word.op),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  grc_dpath #(
    .MAP_DIM (MAP_DIM)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (req_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (rsp_word)
  );

  `GRC_ASSERT(a_clear_blocks_input, cmd.clear_step |-> !req.ready, "word accepted during map clear")
  `GRC_ASSERT(a_load_into_free_reg, cmd.out_load |-> (!rsp.valid || rsp.ready), "result overwritten")
  `GRC_ASSERT(a_result_from_load, $rose(rsp.valid) |-> $past(cmd.out_load), "result without a cast")
  `GRC_ASSERT(a_tile_write_idle, cmd.tile_write |-> (req.ready && req.valid), "stray tile write")

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the grid ray caster: a queue-fed driver offers tile
// writes and casts, a clocked monitor predicts every cast from its own copy of
// the wall map and compares each returned word field by field, over several
// column and row settings with random idling on both channels
// ----------------------------------------------------------------------------
module tb;
  import grc_pkg::*;

  localparam longint TAN_LIM  = (longint'(1) << (FRAC_BITS + SAT_SHIFT)) - 1;
  localparam longint COMP_LIM = 64'sd2147483647;
  localparam longint ONE      = longint'(1) << FRAC_BITS;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;

  grc_chan_if #(.payload_t(req_t)) req_ch ();
  grc_chan_if #(.payload_t(rsp_t)) rsp_ch ();

  grid_ray_caster uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  req_t pending_words[$];
  rsp_t expected_hits[$];
  bit   wall_bits [MAP_DIM_DEF*MAP_DIM_DEF];
  int   cols_in_use;
  int   rows_in_use;
  int   err_count;
  int   req_acc, req_seen, rsp_acc, rsp_seen;
  int   send_gap, recv_wait;
  bit   burst;
  bit   hold_rsp;

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  function automatic longint eff_dim(int v);
    return (v > MAP_DIM_DEF) ? MAP_DIM_DEF : v;
  endfunction

  function automatic bit is_wall(longint col, longint row);
    if (col < 0 || row < 0 || col >= eff_dim(cols_in_use) || row >= eff_dim(rows_in_use))
      return 1'b1;
    return wall_bits[row*MAP_DIM_DEF + col];
  endfunction

  function automatic bit inside_map(longint x, longint y);
    return x >= 0 && x < (eff_dim(cols_in_use) << FRAC_BITS)
        && y >= 0 && y < (eff_dim(rows_in_use) << FRAC_BITS);
  endfunction

  function automatic void ray_dir(input logic [ANGLE_BITS-1:0] a,
                                  output longint c, output longint s);
    logic [31:0] phase;
    longint x, y, z, xs, ys;
    phase = {a, 20'd0};
    x = longint'(1) << 30;
    y = 0;
    z = longint'(phase[29:0]);
    if (z != 0) begin
      for (int i = 0; i < CORD_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys; y = y + xs; z = z - longint'(ATAN_TURN[i]);
        end else begin
          x = x + ys; y = y - xs; z = z + longint'(ATAN_TURN[i]);
        end
      end
    end
    case (phase[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint slope(longint num, longint den);
    longint an, ad, mag;
    bit neg;
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    neg = (num < 0) != (den < 0);
    if (ad == 0) begin
      mag = TAN_LIM;
      neg = num < 0;
    end else begin
      mag = (an << FRAC_BITS) / ad;
      if (mag > TAN_LIM) mag = TAN_LIM;
    end
    return neg ? -mag : mag;
  endfunction

  function automatic longint unsigned dist_sq(longint dx, longint dy);
    longint a, b;
    a = dx > COMP_LIM ? COMP_LIM : (dx < -COMP_LIM ? -COMP_LIM : dx);
    b = dy > COMP_LIM ? COMP_LIM : (dy < -COMP_LIM ? -COMP_LIM : dy);
    return longint'(unsigned'(a*a)) + longint'(unsigned'(b*b));
  endfunction

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [OUT_W-1:0] clip_out(longint v);
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    return v[OUT_W-1:0];
  endfunction

  function automatic rsp_t predict_hit(req_t w);
    longint px, py, c, s, tanv, cotv, hx, hy, vx, vy, stx, sty;
    longint unsigned hsq, vsq, dsq, root_v;
    int a;
    bit down, right, vert;
    rsp_t r;
    px = longint'(w.pos_x);
    py = longint'(w.pos_y);
    a = int'(w.heading);
    down = a > 0 && a < 2048;
    right = a < 1024 || a > 3072;
    ray_dir(w.heading, c, s);
    tanv = slope(s, c);
    cotv = slope(c, s);
    hy = (py >>> FRAC_BITS) <<< FRAC_BITS;
    if (down) hy = hy + ONE;
    hx = px + (((hy - py) * cotv) >>> FRAC_BITS);
    stx = cotv < 0 ? -cotv : cotv;
    if (!right) stx = -stx;
    sty = down ? ONE : -ONE;
    while (inside_map(hx, hy)) begin
      if (is_wall(hx >>> FRAC_BITS, (hy >>> FRAC_BITS) - (down ? 0 : 1))) break;
      hx = hx + stx;
      hy = hy + sty;
    end
    vx = (px >>> FRAC_BITS) <<< FRAC_BITS;
    if (right) vx = vx + ONE;
    vy = py + (((vx - px) * tanv) >>> FRAC_BITS);
    stx = right ? ONE : -ONE;
    sty = tanv < 0 ? -tanv : tanv;
    if (!down) sty = -sty;
    while (inside_map(vx, vy)) begin
      if (is_wall((vx >>> FRAC_BITS) - (right ? 0 : 1), vy >>> FRAC_BITS)) break;
      vx = vx + stx;
      vy = vy + sty;
    end
    hsq = dist_sq(hx - px, hy - py);
    vsq = dist_sq(vx - px, vy - py);
    vert = !(vsq > hsq);
    dsq = vert ? vsq : hsq;
    root_v = int_root(dsq);
    if (root_v > 64'hFFFFFF) root_v = 64'hFFFFFF;
    r.hit_x = clip_out(vert ? vx : hx);
    r.hit_y = clip_out(vert ? vy : hy);
    r.distance = root_v[OUT_W-1:0];
    r.vertical_hit = vert;
    return r;
  endfunction

  // monitor: predict on accepted requests, check accepted responses
  always @(posedge clk) begin
    rsp_t exp_w;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        req_acc++;
        if (req_ch.data.op == OP_TILE)
          wall_bits[req_ch.data.tile_row*MAP_DIM_DEF + req_ch.data.tile_col] =
            req_ch.data.tile_is_wall;
        else
          expected_hits.push_back(predict_hit(req_ch.data));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_acc++;
        if (expected_hits.size() == 0) begin
          $error("unexpected word: hit_x %0d", rsp_ch.data.hit_x);
          err_count++;
        end else begin
          exp_w = expected_hits.pop_front();
          if (rsp_ch.data.hit_x !== exp_w.hit_x) begin
            $error("hit_x expected %0d got %0d", exp_w.hit_x, rsp_ch.data.hit_x);
            err_count++;
          end
          if (rsp_ch.data.hit_y !== exp_w.hit_y) begin
            $error("hit_y expected %0d got %0d", exp_w.hit_y, rsp_ch.data.hit_y);
            err_count++;
          end
          if (rsp_ch.data.distance !== exp_w.distance) begin
            $error("distance expected %0d got %0d", exp_w.distance, rsp_ch.data.distance);
            err_count++;
          end
          if (rsp_ch.data.vertical_hit !== exp_w.vertical_hit) begin
            $error("vertical_hit expected %0d got %0d", exp_w.vertical_hit,
                   rsp_ch.data.vertical_hit);
            err_count++;
          end
        end
      end
    end
  end

  // driver
  always @(negedge clk) begin
    logic nxt_valid;
    if (!rst) begin
      nxt_valid = req_ch.valid;
      if (req_ch.valid && req_acc != req_seen) begin
        req_seen = req_acc;
        void'(pending_words.pop_front());
        send_gap = burst ? 0 : $urandom_range(0, 13);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_words.size() > 0) begin
          nxt_valid = 1'b1;
          req_ch.data <= pending_words[0];
        end
      end
      req_ch.valid <= nxt_valid;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst) begin
      if (rsp_acc != rsp_seen) begin
        rsp_seen = rsp_acc;
        recv_wait = hold_rsp ? 3000 : (burst ? 0 : $urandom_range(0, 13));
        hold_rsp = 1'b0;
      end
      rsp_ch.ready <= (recv_wait == 0);
      if (recv_wait > 0) recv_wait--;
    end
  end

  task automatic wait_idle();
    while (pending_words.size() > 0 || req_ch.valid || expected_hits.size() > 0)
      @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_dims(int c, int r);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_MAP_COLS;
    cfg_data <= CFG_W'(c);
    cols_in_use = c;
    @(negedge clk);
    cfg_index <= REG_MAP_ROWS;
    cfg_data <= CFG_W'(r);
    rows_in_use = r;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_tile(int row, int col, bit wall);
    req_t w;
    w = '0;
    w.op = OP_TILE;
    w.tile_row = TILE_W'(row);
    w.tile_col = TILE_W'(col);
    w.tile_is_wall = wall;
    w.pos_x = POS_W'($urandom);
    w.pos_y = POS_W'($urandom);
    w.heading = ANGLE_BITS'($urandom);
    pending_words.push_back(w);
  endtask

  task automatic add_cast(int px, int py, int ang);
    req_t w;
    w = '0;
    w.op = OP_CAST;
    w.tile_row = TILE_W'($urandom);
    w.tile_col = TILE_W'($urandom);
    w.tile_is_wall = 1'($urandom);
    w.pos_x = POS_W'(px);
    w.pos_y = POS_W'(py);
    w.heading = ANGLE_BITS'(ang);
    pending_words.push_back(w);
  endtask

  function automatic int rand_pos(longint ed);
    if (ed == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, 4194303);
    return $urandom_range(0, int'(ed * 65536) - 1);
  endfunction

  initial begin
    static int cols_set [8] = '{64, 1, 127, 0, 5, 64, 17, 40};
    static int rows_set [8] = '{64, 1, 3, 127, 0, 12, 64, 40};
    static int axis_set [8] = '{0, 1024, 2048, 3072, 1, 4095, 1023, 2049};
    int density;
    longint ec, er;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_MAP_COLS;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    cols_in_use = 64;
    rows_in_use = 64;
    err_count = 0;
    burst = 1'b0;
    hold_rsp = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: map corners, axis rays, position extremes
    add_tile(0, 0, 1'b1);
    add_tile(63, 63, 1'b1);
    add_tile(10, 12, 1'b1);
    add_tile(10, 12, 1'b0);
    add_tile(20, 20, 1'b1);
    add_cast(20*65536 + 32768, 10*65536 + 32768, 0);
    add_cast(20*65536 + 32768, 10*65536 + 32768, 1024);
    add_cast(20*65536 + 32768, 30*65536 + 32768, 3072);
    add_cast(30*65536, 20*65536, 2048);
    add_cast(0, 0, 512);
    add_cast(4194303, 4194303, 2560);
    add_cast(0, 4194303, 3584);
    add_cast(4194303, 0, 1536);
    add_cast(10*65536, 10*65536, 1);
    add_cast(10*65536, 10*65536, 4095);
    add_cast(10*65536, 10*65536, 1023);
    add_cast(10*65536, 10*65536, 3073);
    add_cast(19*65536 + 1, 19*65536 + 1, 512);
    add_cast(32*65536, 32*65536, 4095);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      set_dims(cols_set[ph], rows_set[ph]);
      ec = eff_dim(cols_in_use);
      er = eff_dim(rows_in_use);
      burst = (ph == 2 || ph == 5);
      density = $urandom_range(0, 60);
      if (ph == 5) hold_rsp = 1'b1;
      for (int k = 0; k < 175; k++) begin
        if ($urandom_range(0, 99) < 40) begin
          if (ec > 0 && er > 0 && $urandom_range(0, 3) != 0)
            add_tile($urandom_range(0, int'(er) - 1), $urandom_range(0, int'(ec) - 1),
                     $urandom_range(0, 99) < density);
          else
            add_tile($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
        end else begin
          add_cast(rand_pos(ec), rand_pos(er),
                   ($urandom_range(0, 7) == 0) ? axis_set[$urandom_range(0, 7)]
                                               : $urandom_range(0, 4095));
        end
      end
      wait_idle();
    end

    repeat (500) @(posedge clk);
    if (err_count == 0 && expected_hits.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/grc_pkg.sv
rtl/grc_chan_if.sv
rtl/grc_ctrl.sv
rtl/grc_dpath.sv
rtl/grid_ray_caster.sv
bench/tb.sv
